[rtl/i2cram_pkg.sv]
// Shared types, constants and helpers for the I2C register access master.
package i2cram_pkg;

    localparam int CFG_DATA_W = 16;

    // Command codes carried by an input item.
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BIT_DELAY  = 2'd0;
    localparam logic [1:0] CFG_WRITE_WAIT = 2'd1;
    localparam logic [1:0] CFG_DEV_ADDR   = 2'd2;

    localparam logic [9:0]  BIT_DELAY_RESET  = 10'd18;
    localparam logic [15:0] WRITE_WAIT_RESET = 16'd250;
    localparam logic [6:0]  DEV_ADDR_RESET   = 7'd111;

    localparam logic [5:0] PH_IDLE = 6'd63;

    // Byte-action offsets inside a written or read byte.
    localparam logic [4:0] WB_ACK_RELEASE = 5'd24;
    localparam logic [4:0] WB_ACK_HIGH    = 5'd25;
    localparam logic [5:0] WB_ACK_SAMPLE  = 6'd26;
    localparam logic [4:0] RB_LAST_BIT    = 5'd16;
    localparam logic [5:0] RB_SAMPLE_MAX  = 6'd15;

    // Position of an action within its three-action data bit.
    localparam logic [1:0] MOD3_TAB [32] = '{
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
        2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
        2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
    };

    typedef enum logic [2:0] {
        SEG_START,
        SEG_WBYTE,
        SEG_STOP,
        SEG_RESTART,
        SEG_RBYTE,
        SEG_WAIT,
        SEG_END
    } seg_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] target_reg;
        logic [7:0] write_data;
        logic       sda_in;
    } in_item_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_ok;
    } out_item_t;

    typedef struct packed {
        logic [9:0]  bit_delay_ticks;
        logic [15:0] write_wait_ticks;
        logic [6:0]  device_address;
    } cfg_t;

    // Which part of the transaction a byte slot holds.
    function automatic seg_t seg_of(input logic is_read, input logic [2:0] idx);
        seg_t s;
        if (is_read)
        begin
            case (idx)
                3'd0:    s = SEG_START;
                3'd1:    s = SEG_WBYTE;
                3'd2:    s = SEG_WBYTE;
                3'd3:    s = SEG_RESTART;
                3'd4:    s = SEG_WBYTE;
                3'd5:    s = SEG_RBYTE;
                3'd6:    s = SEG_STOP;
                default: s = SEG_END;
            endcase
        end
        else
        begin
            case (idx)
                3'd0:    s = SEG_START;
                3'd1:    s = SEG_WBYTE;
                3'd2:    s = SEG_WBYTE;
                3'd3:    s = SEG_WBYTE;
                3'd4:    s = SEG_STOP;
                3'd5:    s = SEG_WAIT;
                default: s = SEG_END;
            endcase
        end
        return s;
    endfunction

    // Number of line actions in a segment.
    function automatic logic [4:0] seg_len(input seg_t s, input logic wait_nz);
        logic [4:0] n;
        case (s)
            SEG_START:   n = 5'd3;
            SEG_WBYTE:   n = 5'd27;
            SEG_STOP:    n = 5'd3;
            SEG_RESTART: n = 5'd4;
            SEG_RBYTE:   n = 5'd18;
            SEG_WAIT:    n = {4'd0, wait_nz};
            default:     n = 5'd0;
        endcase
        return n;
    endfunction

endpackage

[rtl/i2cram_seq.sv]
// Bus sequencer: transaction state and the per-tick next-state and result logic.
module i2cram_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  i2cram_pkg::in_item_t item,
    input  i2cram_pkg::cfg_t     cfg,
    output i2cram_pkg::out_item_t res
);
    import i2cram_pkg::*;

    logic [5:0]  phase_reg, phase_next;
    logic [15:0] delay_reg, delay_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  byte_index_reg, byte_index_next;
    logic        is_read_reg, is_read_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  rx_reg, rx_next;
    logic        ack_reg, ack_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        done;

    always_comb
    begin
        logic        do_fetch;
        logic        exec_en;
        logic        sample_en;
        logic        wait_nz;
        logic [2:0]  idx0;
        logic [2:0]  idx1;
        logic [2:0]  idx2;
        logic [5:0]  ph0;
        seg_t        seg0;
        seg_t        seg1;
        seg_t        seg2;
        seg_t        eseg;
        seg_t        sseg;
        logic [2:0]  eidx;
        logic [4:0]  ep;
        logic [15:0] op_len;
        logic [7:0]  dev;
        logic [7:0]  tx;
        logic [7:0]  sh;

        phase_next      = phase_reg;
        delay_next      = delay_reg;
        shift_next      = shift_reg;
        byte_index_next = byte_index_reg;
        is_read_next    = is_read_reg;
        addr_next       = addr_reg;
        data_next       = data_reg;
        rx_next         = rx_reg;
        ack_next        = ack_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        done            = 1'b0;
        do_fetch        = 1'b0;
        exec_en         = 1'b0;
        sample_en       = 1'b0;
        idx0            = byte_index_reg;
        ph0             = phase_reg;
        eseg            = SEG_END;
        eidx            = 3'd0;
        ep              = 5'd0;
        op_len          = 16'd1;
        wait_nz         = (cfg.write_wait_ticks != 16'd0);
        dev             = {cfg.device_address, 1'b0};
        tx              = 8'd0;
        sh              = shift_reg;

        if (phase_reg == PH_IDLE)
        begin
            if ((item.command == CMD_WRITE) || (item.command == CMD_READ))
            begin
                is_read_next = (item.command == CMD_READ);
                addr_next    = item.target_reg;
                data_next    = item.write_data;
                idx0         = 3'd0;
                ph0          = 6'd0;
                do_fetch     = 1'b1;
            end
        end
        else if (delay_reg != 16'd0)
        begin
            delay_next = delay_reg - 16'd1;
            sample_en  = (delay_next == 16'd0);
        end
        else
        begin
            do_fetch = 1'b1;
        end

        // A finished segment moves on to the next slot; a skipped write wait
        // can advance two slots in the same tick.
        idx1 = idx0 + 3'd1;
        idx2 = idx0 + 3'd2;
        seg0 = seg_of(is_read_next, idx0);
        seg1 = seg_of(is_read_next, idx1);
        seg2 = seg_of(is_read_next, idx2);

        if (do_fetch)
        begin
            if (seg0 == SEG_END)
            begin
                done            = 1'b1;
                byte_index_next = idx0;
            end
            else if (ph0 < {1'b0, seg_len(seg0, wait_nz)})
            begin
                exec_en = 1'b1;
                eseg    = seg0;
                eidx    = idx0;
                ep      = ph0[4:0];
            end
            else if (seg1 == SEG_END)
            begin
                done            = 1'b1;
                byte_index_next = idx1;
            end
            else if (seg_len(seg1, wait_nz) != 5'd0)
            begin
                exec_en = 1'b1;
                eseg    = seg1;
                eidx    = idx1;
            end
            else if (seg2 == SEG_END)
            begin
                done            = 1'b1;
                byte_index_next = idx2;
            end
            else
            begin
                exec_en = 1'b1;
                eseg    = seg2;
                eidx    = idx2;
            end
        end

        if (done)
        begin
            phase_next = PH_IDLE;
        end

        if (exec_en)
        begin
            byte_index_next = eidx;
            op_len = (cfg.bit_delay_ticks == 10'd0) ? 16'd1 : {6'd0, cfg.bit_delay_ticks};
            case (eidx)
                3'd1:    tx = dev;
                3'd2:    tx = addr_next;
                3'd3:    tx = data_next;
                default: tx = dev | 8'd1;
            endcase
            case (eseg)
                SEG_START:
                begin
                    if (ep == 5'd0)
                        sda_next = 1'b1;
                    else if (ep == 5'd1)
                        sda_next = 1'b0;
                    else
                        scl_next = 1'b0;
                end
                SEG_STOP:
                begin
                    if (ep == 5'd0)
                        sda_next = 1'b0;
                    else if (ep == 5'd1)
                        scl_next = 1'b1;
                    else
                        sda_next = 1'b1;
                end
                SEG_RESTART:
                begin
                    if (ep == 5'd0)
                        sda_next = 1'b1;
                    else if (ep == 5'd1)
                        scl_next = 1'b1;
                    else if (ep == 5'd2)
                        sda_next = 1'b0;
                    else
                        scl_next = 1'b0;
                end
                SEG_WBYTE:
                begin
                    if (ep == 5'd0)
                        sh = tx;
                    if (ep < WB_ACK_RELEASE)
                    begin
                        case (MOD3_TAB[ep])
                            2'd0:    sda_next = sh[7];
                            2'd1:    scl_next = 1'b1;
                            default:
                            begin
                                scl_next = 1'b0;
                                sh       = {sh[6:0], 1'b0};
                            end
                        endcase
                    end
                    else if (ep == WB_ACK_RELEASE)
                        sda_next = 1'b1;
                    else if (ep == WB_ACK_HIGH)
                        scl_next = 1'b1;
                    else
                        scl_next = 1'b0;
                    shift_next = sh;
                end
                SEG_RBYTE:
                begin
                    if (ep == 5'd0)
                        sh = 8'd0;
                    if (ep < RB_LAST_BIT)
                    begin
                        if (!ep[0])
                        begin
                            sda_next = 1'b1;
                            scl_next = 1'b1;
                        end
                        else
                            scl_next = 1'b0;
                    end
                    else if (ep == RB_LAST_BIT)
                    begin
                        sda_next = 1'b1;
                        scl_next = 1'b1;
                        rx_next  = sh;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b1;
                    end
                    shift_next = sh;
                end
                default:
                begin
                    op_len = wait_nz ? cfg.write_wait_ticks : 16'd1;
                end
            endcase
            phase_next = {1'b0, ep} + 6'd1;
            delay_next = op_len - 16'd1;
            sample_en  = (op_len == 16'd1);
        end

        // SDA is sampled on the last tick of an SCL-high action.
        sseg = seg_of(is_read_next, byte_index_next);
        if (sample_en)
        begin
            if ((sseg == SEG_WBYTE) && (phase_next == WB_ACK_SAMPLE))
                ack_next = ~item.sda_in;
            else if ((sseg == SEG_RBYTE) && phase_next[0] && (phase_next <= RB_SAMPLE_MAX))
                shift_next = {shift_next[6:0], item.sda_in};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            delay_reg      <= 16'd0;
            shift_reg      <= 8'd0;
            byte_index_reg <= 3'd0;
            is_read_reg    <= 1'b0;
            addr_reg       <= 8'd0;
            data_reg       <= 8'd0;
            rx_reg         <= 8'd0;
            ack_reg        <= 1'b1;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            delay_reg      <= delay_next;
            shift_reg      <= shift_next;
            byte_index_reg <= byte_index_next;
            is_read_reg    <= is_read_next;
            addr_reg       <= addr_next;
            data_reg       <= data_next;
            rx_reg         <= rx_next;
            ack_reg        <= ack_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
        end
    end

    always_comb
    begin
        res.scl       = scl_next;
        res.sda_out   = sda_next;
        res.busy_res  = (phase_next != PH_IDLE);
        res.done_res  = done;
        res.read_data = rx_next;
        res.ack_ok    = ack_next;
    end

endmodule

[rtl/i2c_register_access_master_top.sv]
// Top level: configuration registers, sequencer and result register with skid stage.
// Each item's result is registered, via the skid stage while res_stall holds it.
// One item per cycle while item_stall is low; each moves the sequencer by one tick.
// A skid stage lets one more item in while a finished result waits on res_stall.
// Reset clears the sequencer to idle with both lines released and the ack flag set,
// and loads the bit delay, write wait and device address with their default values.
module i2c_register_access_master_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  i2cram_pkg::in_item_t               item_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output i2cram_pkg::out_item_t              res_data,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [i2cram_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import i2cram_pkg::*;

    cfg_t      cfg_reg;
    out_item_t step_res;
    out_item_t out_reg;
    out_item_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      accept;
    logic      out_free;

    assign accept   = item_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_delay_ticks  <= BIT_DELAY_RESET;
            cfg_reg.write_wait_ticks <= WRITE_WAIT_RESET;
            cfg_reg.device_address   <= DEV_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BIT_DELAY:  cfg_reg.bit_delay_ticks  <= cfg_data[9:0];
                CFG_WRITE_WAIT: cfg_reg.write_wait_ticks <= cfg_data[15:0];
                CFG_DEV_ADDR:   cfg_reg.device_address   <= cfg_data[6:0];
                default:        ;
            endcase
        end
    end

    i2cram_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (accept),
        .item  (item_data),
        .cfg   (cfg_reg),
        .res   (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : step_res;
        end
        else if (accept)
        begin
            skid_reg <= step_res;
        end
    end

    assign item_stall = skid_valid_reg;
    assign res_valid  = out_valid_reg;
    assign res_data   = out_reg;

endmodule

[rtl/i2cram_chk.sv]
// Port-level checks for the I2C register access master, bound to the top level.
module i2cram_chk (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  item_stall,
    input logic                  res_valid,
    input logic                  res_stall,
    input i2cram_pkg::out_item_t res_data
);
    import i2cram_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

    // The input side only stalls while a result is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> res_valid)
        else $error("input stalled with empty result register");

    // A finishing tick is never busy and leaves both lines released.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.done_res |->
            !res_data.busy_res && res_data.scl && res_data.sda_out)
        else $error("done shown with busy set or lines driven");

    // Outside a transaction the bus is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.busy_res |-> res_data.scl && res_data.sda_out)
        else $error("bus driven while not busy");

endmodule

bind i2c_register_access_master_top i2cram_chk u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_stall (item_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data)
);
